// ----- design/rppe_pkg.sv -----
// shared types, widths and constants for the relative position packet encoder
package rppe_pkg;

	// field widths
	localparam int OFS_W   = 16;
	localparam int MAG_W   = 10;
	localparam int RAW_W   = 12;
	localparam int MV_W    = 13;
	localparam int LVL_W   = 4;
	localparam int HDR_W   = 3;
	localparam int FRAME_W = 40;
	localparam int LVL_N   = 16;

	// converter scaling: millivolts = raw * 6600 / 4096
	localparam int RAW_SHIFT = 12;
	localparam int SCALE_W   = RAW_W + MV_W;
	localparam logic [MV_W-1:0] MV_SCALE = MV_W'(6600);

	// header codes
	localparam logic [HDR_W-1:0] HDR_LANDED = 3'b111;
	localparam logic [HDR_W-1:0] HDR_FLIGHT = 3'b000;

	// charge level thresholds in millivolts, index 0 unused
	localparam logic [MV_W-1:0] CHARGE_MV [LVL_N] = '{
		13'd0,    13'd3429, 13'd3468, 13'd3498, 13'd3523, 13'd3542, 13'd3563, 13'd3588,
		13'd3617, 13'd3650, 13'd3687, 13'd3727, 13'd3773, 13'd3823, 13'd3882, 13'd4193
	};

	typedef logic [OFS_W-1:0] mag_t;
	typedef logic [LVL_W-1:0] lvl_t;

	// per stage load enables and valid flags
	typedef struct packed {
		logic en_s1;
		logic en_s2;
		logic en_s3;
		logic vld_s1;
		logic vld_s2;
		logic vld_s3;
	} pipe_ctl_t;

endpackage

// ----- design/rppe_split.sv -----
// two's complement offset to sign and magnitude
module rppe_split
	import rppe_pkg::*;
(
	input  logic [OFS_W-1:0] value,
	output logic             sign,
	output mag_t             mag
);

	// negate when the top bit is set; the most negative value gives 0x8000
	always_comb begin
		sign = value[OFS_W-1];
		mag  = sign ? (~value + OFS_W'(1)) : value;
	end

endmodule

// ----- design/rppe_pipe_ctrl.sv -----
// valid tracking and load enables for the three stage pipeline
module rppe_pipe_ctrl
	import rppe_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	input  logic      out_stall,
	output logic      in_stall,
	output pipe_ctl_t ctl
);

	logic vld_s1;
	logic vld_s2;
	logic vld_s3;
	logic adv1;
	logic adv2;
	logic adv3;

	// a stage moves when it is empty or the next one moves
	always_comb begin
		adv3 = !vld_s3 || !out_stall;
		adv2 = !vld_s2 || adv3;
		adv1 = !vld_s1 || adv2;
	end

	// valid flags follow the words down the pipe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else begin
			if (adv1) vld_s1 <= in_valid;
			if (adv2) vld_s2 <= vld_s1;
			if (adv3) vld_s3 <= vld_s2;
		end
	end

	assign in_stall   = !adv1;
	assign ctl.en_s1  = adv1;
	assign ctl.en_s2  = adv2;
	assign ctl.en_s3  = adv3;
	assign ctl.vld_s1 = vld_s1;
	assign ctl.vld_s2 = vld_s2;
	assign ctl.vld_s3 = vld_s3;

endmodule

// ----- design/relative_position_packet_encoder_core.sv -----
// top level of the relative position packet encoder
//
//  channel | handshake             | payload
//  --------+-----------------------+--------------------------------------------------
//  input   | in_valid / in_stall   | lat_offset, lon_offset, alt_offset, battery_raw, landed
//  output  | out_valid / out_stall | frame, charge_level, magnitude_overflow
//
// one word per cycle unless the output stalls; stage 3 holds the result register
// stage 1: sign split and battery scaling multiply; stage 2: threshold compares
// and overflow; stage 3: charge level encode and frame packing
// reset clears only the valid flags; payload registers are left as they are
// a stalled output holds its word while earlier stages keep filling bubbles
module relative_position_packet_encoder_core
	import rppe_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [OFS_W-1:0]    lat_offset,
	input  logic [OFS_W-1:0]    lon_offset,
	input  logic [OFS_W-1:0]    alt_offset,
	input  logic [RAW_W-1:0]    battery_raw,
	input  logic                landed,
	output logic                out_valid,
	input  logic                out_stall,
	output logic [FRAME_W-1:0]  frame,
	output logic [LVL_W-1:0]    charge_level,
	output logic                magnitude_overflow
);

	pipe_ctl_t ctl;

	logic lat_sign;
	logic lon_sign;
	logic alt_sign;
	mag_t lat_mag;
	mag_t lon_mag;
	mag_t alt_mag;

	logic               lat_sign_s1;
	logic               lon_sign_s1;
	logic               alt_sign_s1;
	mag_t               lat_mag_s1;
	mag_t               lon_mag_s1;
	mag_t               alt_mag_s1;
	logic [SCALE_W-1:0] scaled_s1;
	logic               landed_s1;

	logic [LVL_N-1:1]   above;
	logic [LVL_N-1:1]   above_s2;
	logic               lat_sign_s2;
	logic               lon_sign_s2;
	logic               alt_sign_s2;
	logic [MAG_W-1:0]   lat_mag_s2;
	logic [MAG_W-1:0]   lon_mag_s2;
	logic [MAG_W-1:0]   alt_mag_s2;
	logic               ovf_s2;
	logic               landed_s2;

	lvl_t               level;
	logic [FRAME_W-1:0] frame_s3;
	lvl_t               level_s3;
	logic               ovf_s3;

	// handshake and stage enables
	rppe_pipe_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.out_stall (out_stall),
		.in_stall  (in_stall),
		.ctl       (ctl)
	);

	// sign and magnitude of each offset
	rppe_split u_split_lat (.value(lat_offset), .sign(lat_sign), .mag(lat_mag));
	rppe_split u_split_lon (.value(lon_offset), .sign(lon_sign), .mag(lon_mag));
	rppe_split u_split_alt (.value(alt_offset), .sign(alt_sign), .mag(alt_mag));

	// stage 1: split offsets, scale battery reading
	always_ff @(posedge clk) begin
		if (ctl.en_s1) begin
			lat_sign_s1 <= lat_sign;
			lon_sign_s1 <= lon_sign;
			alt_sign_s1 <= alt_sign;
			lat_mag_s1  <= lat_mag;
			lon_mag_s1  <= lon_mag;
			alt_mag_s1  <= alt_mag;
			scaled_s1   <= SCALE_W'(battery_raw) * SCALE_W'(MV_SCALE);
			landed_s1   <= landed;
		end
	end

	// scaled reading against each threshold times 4096
	always_comb begin
		for (int i = 1; i < LVL_N; i++) begin
			above[i] = scaled_s1 > {CHARGE_MV[i], RAW_SHIFT'(0)};
		end
	end

	// stage 2: compares, truncated magnitudes, overflow
	always_ff @(posedge clk) begin
		if (ctl.en_s2) begin
			above_s2    <= above;
			lat_sign_s2 <= lat_sign_s1;
			lon_sign_s2 <= lon_sign_s1;
			alt_sign_s2 <= alt_sign_s1;
			lat_mag_s2  <= lat_mag_s1[MAG_W-1:0];
			lon_mag_s2  <= lon_mag_s1[MAG_W-1:0];
			alt_mag_s2  <= alt_mag_s1[MAG_W-1:0];
			ovf_s2      <= (|lat_mag_s1[OFS_W-1:MAG_W]) || (|lon_mag_s1[OFS_W-1:MAG_W])
			            || (|alt_mag_s1[OFS_W-1:MAG_W]);
			landed_s2   <= landed_s1;
		end
	end

	// highest threshold exceeded
	always_comb begin
		level = '0;
		for (int i = 1; i < LVL_N; i++) begin
			if (above_s2[i]) level = LVL_W'(i);
		end
	end

	// stage 3: pack the frame
	always_ff @(posedge clk) begin
		if (ctl.en_s3) begin
			frame_s3 <= {landed_s2 ? HDR_LANDED : HDR_FLIGHT,
			             lat_sign_s2, lat_mag_s2,
			             lon_sign_s2, lon_mag_s2,
			             alt_sign_s2, alt_mag_s2,
			             level};
			level_s3 <= level;
			ovf_s3   <= ovf_s2;
		end
	end

	assign out_valid          = ctl.vld_s3;
	assign frame              = frame_s3;
	assign charge_level       = level_s3;
	assign magnitude_overflow = ovf_s3;

	// charge level in the frame tail matches the separate field
	a_level_copy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> frame[LVL_W-1:0] == charge_level)
		else $error("charge level field differs from frame tail");

	// header is all ones or all zeros
	a_header: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (frame[FRAME_W-1:FRAME_W-HDR_W] == HDR_LANDED
		            || frame[FRAME_W-1:FRAME_W-HDR_W] == HDR_FLIGHT))
		else $error("malformed frame header");

	// an empty output stage never pushes back on the input
	a_no_false_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> !in_stall)
		else $error("input stalled with empty output stage");

	// a full pipe behind a stalled output must stall the input
	a_full_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl.vld_s1 && ctl.vld_s2 && ctl.vld_s3 && out_stall) |-> in_stall)
		else $error("input accepted into a full stalled pipe");

endmodule
